>>> rtl/rrpl_pkg.sv
package rrpl_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int ID_W            = 8;
  localparam int KIND_W          = 2;

  localparam logic [KIND_W-1:0] OP_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] OP_NEXT   = 2'd2;
  localparam logic [KIND_W-1:0] OP_CLEAR  = 2'd3;

endpackage

>>> rtl/rrpl_store.sv
module rrpl_store #(
  parameter int DEPTH = rrpl_pkg::MAX_ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [rrpl_pkg::ID_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rrpl_pkg::ID_W-1:0] wr_data
);
  import rrpl_pkg::*;

  logic [ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/rrpl_seq.sv
module rrpl_seq #(
  parameter int MAX_ENTRIES = rrpl_pkg::MAX_ENTRIES_DEF,
  parameter int IDX_W       = $clog2(MAX_ENTRIES),
  parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rrpl_pkg::KIND_W-1:0] kind,
  input  logic [rrpl_pkg::ID_W-1:0]   ident,
  output logic                        rd_en,
  output logic [IDX_W-1:0]            rd_addr,
  input  logic [rrpl_pkg::ID_W-1:0]   rd_data,
  output logic                        wr_en,
  output logic [IDX_W-1:0]            wr_addr,
  output logic [rrpl_pkg::ID_W-1:0]   wr_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [rrpl_pkg::ID_W-1:0]   res_ident,
  output logic                        res_ok,
  output logic [CNT_W-1:0]            res_count
);
  import rrpl_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO  = CNT_W'(2);

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  cursor, cursor_next;
  logic [CNT_W-1:0]  rd_idx, rd_idx_next;
  logic              pend;
  logic [KIND_W-1:0] op;
  logic [ID_W-1:0]   id;
  logic [ID_W-1:0]   res_ident_next;
  logic              res_ok_next;

  logic              scan_issue;
  logic [CNT_W-1:0]  pend_idx;
  logic [CNT_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  fetch_idx;
  logic [CNT_W-1:0]  fetch_inc;

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res_count = count;

  // reads are issued the cycle before their compare/write-back
  assign scan_issue = ((state == S_SCAN) || (state == S_SHIFT)) && (rd_idx < count);
  assign pend_idx   = rd_idx - ONE;
  assign wr_idx     = rd_idx - TWO;
  assign fetch_idx  = (CNT_W'(cursor) >= count) ? '0 : cursor;
  assign fetch_inc  = CNT_W'(fetch_idx) + ONE;

  always_comb begin
    state_next     = state;
    count_next     = count;
    cursor_next    = cursor;
    rd_idx_next    = rd_idx;
    res_ident_next = res_ident;
    res_ok_next    = res_ok;
    rd_en          = 1'b0;
    rd_addr        = rd_idx[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = count[IDX_W-1:0];
    wr_data        = id;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          rd_idx_next    = '0;
          res_ident_next = '0;
          res_ok_next    = 1'b0;
          case (kind)
            OP_APPEND: begin
              if (count == FULL) begin
                state_next = S_DONE;
              end else if (count == '0) begin
                wr_en       = 1'b1;
                wr_data     = ident;
                count_next  = count + ONE;
                res_ok_next = 1'b1;
                state_next  = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            OP_REMOVE: begin
              state_next = (count == '0) ? S_DONE : S_SCAN;
            end
            OP_NEXT: begin
              if (count == '0) begin
                state_next = S_DONE;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = fetch_idx;
                state_next = S_FETCH;
              end
            end
            default: begin
              count_next  = '0;
              cursor_next = '0;
              res_ok_next = 1'b1;
              state_next  = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_issue) begin
          rd_en       = 1'b1;
          rd_idx_next = rd_idx + ONE;
        end
        if (pend) begin
          if (rd_data == id) begin
            // remove: read of the following entry is already in flight
            state_next = (op == OP_REMOVE) ? S_SHIFT : S_DONE;
          end else if (pend_idx == count - ONE) begin
            if (op == OP_APPEND) begin
              wr_en       = 1'b1;
              count_next  = count + ONE;
              res_ok_next = 1'b1;
            end
            state_next = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        if (scan_issue) begin
          rd_en       = 1'b1;
          rd_idx_next = rd_idx + ONE;
        end
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = wr_idx[IDX_W-1:0];
          wr_data = rd_data;
        end else begin
          count_next = count - ONE;
          if (CNT_W'(cursor) >= count - ONE) begin
            cursor_next = '0;
          end
          res_ok_next = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_FETCH: begin
        res_ident_next = rd_data;
        res_ok_next    = 1'b1;
        cursor_next    = (fetch_inc >= count) ? '0 : fetch_inc[IDX_W-1:0];
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      cursor <= '0;
      pend   <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      cursor <= cursor_next;
      pend   <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx    <= rd_idx_next;
    res_ident <= res_ident_next;
    res_ok    <= res_ok_next;
    if (state == S_IDLE && in_valid) begin
      op <= kind;
      id <= ident;
    end
  end

endmodule

>>> rtl/round_robin_poll_list_core.sv
// Round-robin poll list: ordered list of unique 8-bit identifiers.
// Input channel (in_valid/in_stall) carries kind and ident; kind selects
// append, remove, next or clear. Output channel (out_valid/out_stall)
// returns exactly one result per input: ident_out, ok and list_count.
// Items are handled one at a time; in_stall is high while an item is
// in progress. Clear, append to a full list, and any operation on an
// empty list finish with no scan; next does one entry-memory read;
// append, or remove of an unlisted identifier, scans the entry memory
// at one read per cycle; remove of a listed identifier scans and then
// shifts the later entries down by write-back.
// The result sits in an output register; the next item is accepted while
// it waits. When out_stall holds, a further result waits inside the
// sequencer and input stays stalled until the register drains.
// Reset empties the list and zeroes the cursor at once; no clearing pass.
module round_robin_poll_list_core #(
  parameter int MAX_ENTRIES = rrpl_pkg::MAX_ENTRIES_DEF,
  parameter int IDX_W       = $clog2(MAX_ENTRIES),
  parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rrpl_pkg::KIND_W-1:0] kind,
  input  logic [rrpl_pkg::ID_W-1:0]   ident,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rrpl_pkg::ID_W-1:0]   ident_out,
  output logic                        ok,
  output logic [CNT_W-1:0]            list_count
);
  import rrpl_pkg::*;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ID_W-1:0]  rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ID_W-1:0]  wr_data;
  logic             res_valid;
  logic             res_ready;
  logic [ID_W-1:0]  res_ident;
  logic             res_ok;
  logic [CNT_W-1:0] res_count;

  rrpl_store #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IDX_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  rrpl_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .ident     (ident),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_ident (res_ident),
    .res_ok    (res_ok),
    .res_count (res_count)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      ident_out  <= res_ident;
      ok         <= res_ok;
      list_count <= res_count;
    end
  end

endmodule

>>> rtl/rrpl_checker.sv
module rrpl_checker #(
  parameter int MAX_ENTRIES = rrpl_pkg::MAX_ENTRIES_DEF,
  parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [rrpl_pkg::ID_W-1:0]   ident_out,
  input logic                        ok,
  input logic [CNT_W-1:0]            list_count
);
  import rrpl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ident_out) && $stable(ok)
      && $stable(list_count))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> list_count <= CNT_W'(MAX_ENTRIES))
    else $error("list count beyond capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> ident_out == '0)
    else $error("failed operation returned an identifier");

endmodule

bind round_robin_poll_list_core rrpl_checker #(
  .MAX_ENTRIES (MAX_ENTRIES),
  .CNT_W       (CNT_W)
) u_rrpl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .ident_out  (ident_out),
  .ok         (ok),
  .list_count (list_count)
);
